/* src/trm_pkg.sv */
// Shared types and constants of the traffic rate meter.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package trm_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int RATE_W         = 40;
    localparam int TIME_W         = 48;
    localparam int BYTES_W        = 32;
    localparam int PKTS_W         = 16;
    localparam int EVCNT_W        = 32;
    localparam int DIV_W          = 14;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_WIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRF_WIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST_RAT  = 3'd4;

    localparam logic [13:0] INTERVAL_RST  = 14'd1000;
    localparam logic [13:0] INTERVAL_MIN  = 14'd100;
    localparam logic [13:0] INTERVAL_MAX  = 14'd10000;
    localparam logic [5:0]  AVG_WIN_RST   = 6'd5;
    localparam logic [5:0]  PRF_WIN_RST   = 6'd10;
    localparam logic [15:0] IDLE_THR_RST  = 16'd3000;
    localparam logic [7:0]  BURST_RAT_RST = 8'd48;

    typedef enum logic [1:0] {
        PRF_IDLE     = 2'd0,
        PRF_CONSTANT = 2'd1,
        PRF_BURSTY   = 2'd2,
        PRF_PERIODIC = 2'd3
    } t_profile;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    go;
        t_alu_op op;
    } t_alu_req;

endpackage
`default_nettype wire

/* src/trm_alu.sv */
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// Depends on trm_pkg for the request struct and the divisor width.
`default_nettype none
module trm_alu #(
    parameter int SUM_W = 47,
    parameter int ACC_W = 99
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  trm_pkg::t_alu_req    i_req,
    input  wire [ACC_W-1:0]      i_a,
    input  wire [SUM_W-1:0]      i_b,
    input  wire [ACC_W-1:0]      i_acc,
    output logic                 o_done,
    output logic [ACC_W-1:0]     o_res
);
    import trm_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    t_alu_op          r_op;
    logic [ACC_W-1:0] r_p;
    logic [ACC_W-1:0] r_sh;
    logic [SUM_W-1:0] r_m;
    logic [DIV_W-1:0] r_d;
    logic [CNT_W-1:0] r_cnt;

    logic [DIV_W:0]   rem2;
    logic             qbit;

    // Restoring step: bring down the next dividend bit, subtract if it fits.
    assign rem2 = {r_p[DIV_W-1:0], r_sh[SUM_W-1]};
    assign qbit = (rem2 >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_p    <= (i_req.op == ALU_MUL) ? i_acc : '0;
                r_sh   <= i_a;
                r_m    <= i_b;
                r_d    <= i_b[DIV_W-1:0];
                r_cnt  <= CNT_W'(SUM_W);
            end else if (r_busy) begin
                if (r_op == ALU_MUL) begin
                    if (r_m == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        if (r_m[0]) begin
                            r_p <= r_p + r_sh;
                        end
                        r_sh <= {r_sh[ACC_W-2:0], 1'b0};
                        r_m  <= {1'b0, r_m[SUM_W-1:1]};
                    end
                end else begin
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_p  <= qbit ? ACC_W'(rem2 - {1'b0, r_d}) : ACC_W'(rem2);
                        r_sh <= {{(ACC_W-SUM_W){1'b0}}, r_sh[SUM_W-2:0], qbit};
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == ALU_MUL) ? r_p : r_sh;

endmodule
`default_nettype wire

/* src/trm_ring.sv */
// Sample ring storage: tick time and combined rate per entry.
// Depends on trm_pkg for field widths; one write and one registered read.
`default_nettype none
module trm_ring #(
    parameter int RING_DEPTH = 64
) (
    input  wire                              i_clk,
    input  wire                              i_we,
    input  wire [$clog2(RING_DEPTH)-1:0]     i_waddr,
    input  wire [trm_pkg::TIME_W-1:0]        i_wtime,
    input  wire [trm_pkg::RATE_W-1:0]        i_wrate,
    input  wire [$clog2(RING_DEPTH)-1:0]     i_raddr,
    output logic [trm_pkg::TIME_W-1:0]       o_rtime,
    output logic [trm_pkg::RATE_W-1:0]       o_rrate
);
    import trm_pkg::*;

    logic [TIME_W-1:0] r_time_mem [RING_DEPTH];
    logic [RATE_W-1:0] r_rate_mem [RING_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_time_mem[i_waddr] <= i_wtime;
            r_rate_mem[i_waddr] <= i_wrate;
        end
        o_rtime <= r_time_mem[i_raddr];
        o_rrate <= r_rate_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* src/traffic_rate_meter_unit.sv */
// Top level of the traffic rate meter: sequencer, counters and result register.
// Depends on trm_pkg, trm_alu and trm_ring.
`default_nettype none
// A data beat (operation 0) with a nonzero byte count adds its byte count and
// one packet to the rx or tx period counters; it gives no result. A tick beat
// (operation 1) closes the period: both rates are formed as
// floor(bytes*1000/interval), the combined rate is pushed into the sample
// ring, and one result beat follows with the windowed mean, the peak, burst
// and idle indications and the traffic profile. Every multiply and divide of
// a tick goes through one shared bit-serial unit; each ring entry that falls
// inside the profile window costs a squaring and, where the burst check runs,
// a further multiply, and the ring is walked through its single read port one
// entry at a time. The input is not ready while a tick is in progress. A
// finished result waits in an output register; a new beat may be taken while
// it waits, but the next tick cannot hand over its result until the previous
// one has been taken. The ring needs no clearing pass after reset: only
// filled entries are read.
module traffic_rate_meter_unit #(
    parameter int RING_DEPTH = trm_pkg::RING_DEPTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Input channel.
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_operation,
    input  wire [trm_pkg::TIME_W-1:0]         i_now_ms,
    input  wire [15:0]                        i_byte_count,
    input  wire                               i_direction,
    // Result channel.
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [trm_pkg::RATE_W-1:0]        o_moving_avg_bps,
    output logic [trm_pkg::RATE_W-1:0]        o_rx_bps,
    output logic [trm_pkg::RATE_W-1:0]        o_tx_bps,
    output logic [trm_pkg::RATE_W-1:0]        o_peak_bps,
    output logic [16:0]                       o_period_packets,
    output logic                              o_burst_flag,
    output logic                              o_idle_event,
    output logic [1:0]                        o_profile,
    output logic                              o_profile_changed,
    output logic [trm_pkg::EVCNT_W-1:0]       o_burst_total,
    output logic [trm_pkg::EVCNT_W-1:0]       o_idle_total,
    // Configuration write port.
    input  wire                               i_cfg_we,
    input  wire [trm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [trm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import trm_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = RATE_W + CNT_W;
    localparam int ACC_W = 2 * SUM_W + 5;

    typedef enum logic [22:0] {
        S_IDLE     = 23'h000001,
        S_RXM      = 23'h000002,
        S_RXD      = 23'h000004,
        S_TXM      = 23'h000008,
        S_TXD      = 23'h000010,
        S_AVG_RD   = 23'h000020,
        S_AVG_CHK  = 23'h000040,
        S_AVG_END  = 23'h000080,
        S_AVG_DV   = 23'h000100,
        S_BRM      = 23'h000200,
        S_PRF_RD   = 23'h000400,
        S_PRF_CHK  = 23'h000800,
        S_PRF_SQ   = 23'h001000,
        S_PRF_EVAL = 23'h002000,
        S_NQ       = 23'h004000,
        S_NQ25     = 23'h008000,
        S_SS       = 23'h010000,
        S_SS26     = 23'h020000,
        S_SR       = 23'h040000,
        S_BR_RD    = 23'h080000,
        S_BR_CHK   = 23'h100000,
        S_BR_MUL   = 23'h200000,
        S_FIN      = 23'h400000
    } t_state;

    // Configuration registers.
    logic [13:0] r_interval;
    logic [5:0]  r_avg_win;
    logic [5:0]  r_prf_win;
    logic [15:0] r_idle_thr;
    logic [7:0]  r_burst_rat;

    // Persistent meter state.
    logic [BYTES_W-1:0] r_rx_bytes, r_tx_bytes;
    logic [PKTS_W-1:0]  r_rx_pkts, r_tx_pkts;
    logic [PTR_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_fill;
    logic [RATE_W-1:0]  r_peak;
    t_profile           r_cur_prof;
    logic               r_idle_st;
    logic               r_seen;
    logic [TIME_W-1:0]  r_last;
    logic [EVCNT_W-1:0] r_burst_cnt, r_idle_cnt;

    // Working registers of one tick.
    t_state             r_state;
    logic [TIME_W-1:0]  r_now;
    logic [RATE_W-1:0]  r_rx, r_tx, r_rate, r_avg;
    logic [16:0]        r_pkts;
    logic [PTR_W-1:0]   r_wslot, r_rp;
    logic [CNT_W-1:0]   r_i, r_n, r_b;
    logic [SUM_W-1:0]   r_sum;
    logic [ACC_W-1:0]   r_q, r_lhs, r_sr;
    logic               r_burst, r_idle_ev;
    t_profile           r_prof;

    // Shared unit request, registered.
    t_alu_req           r_req;
    logic [ACC_W-1:0]   r_alu_a, r_alu_acc;
    logic [SUM_W-1:0]   r_alu_b;

    logic               r_out_valid;

    logic               alu_done;
    logic [ACC_W-1:0]   alu_res;
    logic [TIME_W-1:0]  rd_time;
    logic [RATE_W-1:0]  rd_rate;
    logic               ring_we;
    logic [RATE_W-1:0]  new_rate;
    logic [13:0]        iv_clamped;
    logic [15:0]        avg_win_ms, prf_win_ms;
    logic               in_avg_win, in_prf_win;
    logic               in_acc, fin_load;
    logic [BYTES_W:0]   rx_sum, tx_sum;
    logic [PTR_W-1:0]   rp_prev;
    logic [RATE_W-1:0]  avg_q;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign fin_load   = (r_state == S_FIN) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign iv_clamped = (r_interval < INTERVAL_MIN) ? INTERVAL_MIN :
                        (r_interval > INTERVAL_MAX) ? INTERVAL_MAX : r_interval;
    assign avg_win_ms = 16'(r_avg_win) * 16'd1000;
    assign prf_win_ms = 16'(r_prf_win) * 16'd1000;

    // An entry stays in a window while its time plus the window reaches now.
    assign in_avg_win = (({1'b0, rd_time} + (TIME_W+1)'(avg_win_ms)) >= {1'b0, r_now});
    assign in_prf_win = (({1'b0, rd_time} + (TIME_W+1)'(prf_win_ms)) >= {1'b0, r_now});

    assign rx_sum  = {1'b0, r_rx_bytes} + (BYTES_W+1)'(i_byte_count);
    assign tx_sum  = {1'b0, r_tx_bytes} + (BYTES_W+1)'(i_byte_count);
    assign rp_prev = (r_rp == '0) ? PTR_W'(RING_DEPTH - 1) : r_rp - 1'b1;
    assign avg_q   = alu_res[RATE_W-1:0];

    assign ring_we  = (r_state == S_TXD) && alu_done;
    assign new_rate = r_rx + alu_res[RATE_W-1:0];

    trm_alu #(
        .SUM_W (SUM_W),
        .ACC_W (ACC_W)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .i_a     (r_alu_a),
        .i_b     (r_alu_b),
        .i_acc   (r_alu_acc),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    trm_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_head),
        .i_wtime (r_now),
        .i_wrate (new_rate),
        .i_raddr (r_rp),
        .o_rtime (rd_time),
        .o_rrate (rd_rate)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= INTERVAL_RST;
            r_avg_win   <= AVG_WIN_RST;
            r_prf_win   <= PRF_WIN_RST;
            r_idle_thr  <= IDLE_THR_RST;
            r_burst_rat <= BURST_RAT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INTERVAL:  r_interval  <= i_cfg_data[13:0];
                CFG_AVG_WIN:   r_avg_win   <= i_cfg_data[5:0];
                CFG_PRF_WIN:   r_prf_win   <= i_cfg_data[5:0];
                CFG_IDLE_THR:  r_idle_thr  <= i_cfg_data;
                CFG_BURST_RAT: r_burst_rat <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sequencer. Each arithmetic step is launched by a registered request and
    // the waiting state moves on when the shared unit reports completion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req       <= '{go: 1'b0, op: ALU_MUL};
            r_rx_bytes  <= '0;
            r_tx_bytes  <= '0;
            r_rx_pkts   <= '0;
            r_tx_pkts   <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_peak      <= '0;
            r_cur_prof  <= PRF_IDLE;
            r_idle_st   <= 1'b0;
            r_seen      <= 1'b0;
            r_last      <= '0;
            r_burst_cnt <= '0;
            r_idle_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_req.go <= 1'b0;
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_operation) begin
                            if (i_byte_count != '0) begin
                                if (i_direction) begin
                                    r_tx_bytes <= tx_sum[BYTES_W] ? '1 : tx_sum[BYTES_W-1:0];
                                    if (r_tx_pkts != '1) r_tx_pkts <= r_tx_pkts + 1'b1;
                                end else begin
                                    r_rx_bytes <= rx_sum[BYTES_W] ? '1 : rx_sum[BYTES_W-1:0];
                                    if (r_rx_pkts != '1) r_rx_pkts <= r_rx_pkts + 1'b1;
                                end
                                r_last    <= i_now_ms;
                                r_seen    <= 1'b1;
                                r_idle_st <= 1'b0;
                            end
                        end else begin
                            r_now     <= i_now_ms;
                            r_req     <= '{go: 1'b1, op: ALU_MUL};
                            r_alu_a   <= ACC_W'(r_rx_bytes);
                            r_alu_b   <= SUM_W'(1000);
                            r_alu_acc <= '0;
                            r_state   <= S_RXM;
                        end
                    end
                end
                S_RXM, S_TXM: begin
                    if (alu_done) begin
                        r_req   <= '{go: 1'b1, op: ALU_DIV};
                        r_alu_a <= alu_res;
                        r_alu_b <= SUM_W'(iv_clamped);
                        r_state <= (r_state == S_RXM) ? S_RXD : S_TXD;
                    end
                end
                S_RXD: begin
                    if (alu_done) begin
                        r_rx      <= alu_res[RATE_W-1:0];
                        r_req     <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a   <= ACC_W'(r_tx_bytes);
                        r_alu_b   <= SUM_W'(1000);
                        r_alu_acc <= '0;
                        r_state   <= S_TXM;
                    end
                end
                S_TXD: begin
                    // The ring write happens on this edge; the walk starts at
                    // the entry just written.
                    if (alu_done) begin
                        r_tx       <= alu_res[RATE_W-1:0];
                        r_rate     <= new_rate;
                        r_pkts     <= 17'(r_rx_pkts) + 17'(r_tx_pkts);
                        r_rx_bytes <= '0;
                        r_tx_bytes <= '0;
                        r_rx_pkts  <= '0;
                        r_tx_pkts  <= '0;
                        r_wslot    <= r_head;
                        r_rp       <= r_head;
                        r_head     <= (r_head == PTR_W'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
                        if (r_fill != CNT_W'(RING_DEPTH)) r_fill <= r_fill + 1'b1;
                        r_i        <= '0;
                        r_n        <= '0;
                        r_sum      <= '0;
                        r_state    <= S_AVG_RD;
                    end
                end
                S_AVG_RD: begin
                    r_state <= (r_i < r_fill) ? S_AVG_CHK : S_AVG_END;
                end
                S_AVG_CHK: begin
                    if (in_avg_win) begin
                        r_sum   <= r_sum + SUM_W'(rd_rate);
                        r_n     <= r_n + 1'b1;
                        r_i     <= r_i + 1'b1;
                        r_rp    <= rp_prev;
                        r_state <= S_AVG_RD;
                    end else begin
                        r_state <= S_AVG_END;
                    end
                end
                S_AVG_END: begin
                    if (r_n == '0) begin
                        r_avg     <= '0;
                        r_req     <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a   <= '0;
                        r_alu_b   <= SUM_W'(r_burst_rat);
                        r_alu_acc <= '0;
                        r_state   <= S_BRM;
                    end else begin
                        r_req   <= '{go: 1'b1, op: ALU_DIV};
                        r_alu_a <= ACC_W'(r_sum);
                        r_alu_b <= SUM_W'(r_n);
                        r_state <= S_AVG_DV;
                    end
                end
                S_AVG_DV: begin
                    if (alu_done) begin
                        r_avg     <= avg_q;
                        r_req     <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a   <= ACC_W'(avg_q);
                        r_alu_b   <= SUM_W'(r_burst_rat);
                        r_alu_acc <= '0;
                        r_state   <= S_BRM;
                    end
                end
                S_BRM: begin
                    if (alu_done) begin
                        if (r_avg > r_peak) r_peak <= r_avg;
                        r_burst <= (r_avg != '0) && (r_rate != '0) &&
                                   (ACC_W'({r_rate, 4'b0000}) > alu_res);
                        if ((r_avg != '0) && (r_rate != '0) &&
                            (ACC_W'({r_rate, 4'b0000}) > alu_res) && (r_burst_cnt != '1)) begin
                            r_burst_cnt <= r_burst_cnt + 1'b1;
                        end
                        r_idle_ev <= 1'b0;
                        if (!r_seen) begin
                            r_idle_st <= 1'b1;
                        end else if (!r_idle_st && (r_now >= r_last) &&
                                     ((r_now - r_last) >= TIME_W'(r_idle_thr))) begin
                            r_idle_st <= 1'b1;
                            r_idle_ev <= 1'b1;
                            if (r_idle_cnt != '1) r_idle_cnt <= r_idle_cnt + 1'b1;
                        end
                        r_i     <= '0;
                        r_n     <= '0;
                        r_sum   <= '0;
                        r_q     <= '0;
                        r_rp    <= r_wslot;
                        r_state <= S_PRF_RD;
                    end
                end
                S_PRF_RD: begin
                    r_state <= (r_i < r_fill) ? S_PRF_CHK : S_PRF_EVAL;
                end
                S_PRF_CHK: begin
                    if (in_prf_win) begin
                        r_sum     <= r_sum + SUM_W'(rd_rate);
                        r_n       <= r_n + 1'b1;
                        r_i       <= r_i + 1'b1;
                        r_rp      <= rp_prev;
                        r_req     <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a   <= ACC_W'(rd_rate);
                        r_alu_b   <= SUM_W'(rd_rate);
                        r_alu_acc <= r_q;
                        r_state   <= S_PRF_SQ;
                    end else begin
                        r_state <= S_PRF_EVAL;
                    end
                end
                S_PRF_SQ: begin
                    if (alu_done) begin
                        r_q     <= alu_res;
                        r_state <= S_PRF_RD;
                    end
                end
                S_PRF_EVAL: begin
                    // Fewer than two samples or a mean below one is idle.
                    if ((r_n < CNT_W'(2)) || (r_sum < SUM_W'(r_n))) begin
                        r_prof  <= PRF_IDLE;
                        r_state <= S_FIN;
                    end else begin
                        r_req     <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a   <= r_q;
                        r_alu_b   <= SUM_W'(r_n);
                        r_alu_acc <= '0;
                        r_state   <= S_NQ;
                    end
                end
                S_NQ: begin
                    if (alu_done) begin
                        r_req     <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a   <= alu_res;
                        r_alu_b   <= SUM_W'(25);
                        r_alu_acc <= '0;
                        r_state   <= S_NQ25;
                    end
                end
                S_NQ25: begin
                    if (alu_done) begin
                        r_lhs     <= alu_res;
                        r_req     <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a   <= ACC_W'(r_sum);
                        r_alu_b   <= r_sum;
                        r_alu_acc <= '0;
                        r_state   <= S_SS;
                    end
                end
                S_SS: begin
                    if (alu_done) begin
                        r_req     <= '{go: 1'b1, op: ALU_MUL};
                        r_alu_a   <= alu_res;
                        r_alu_b   <= SUM_W'(26);
                        r_alu_acc <= '0;
                        r_state   <= S_SS26;
                    end
                end
                S_SS26: begin
                    // Low spread against the mean squared means constant.
                    if (alu_done) begin
                        if (r_lhs < alu_res) begin
                            r_prof  <= PRF_CONSTANT;
                            r_state <= S_FIN;
                        end else begin
                            r_req     <= '{go: 1'b1, op: ALU_MUL};
                            r_alu_a   <= ACC_W'(r_sum);
                            r_alu_b   <= SUM_W'(r_burst_rat);
                            r_alu_acc <= '0;
                            r_state   <= S_SR;
                        end
                    end
                end
                S_SR: begin
                    if (alu_done) begin
                        r_sr    <= alu_res;
                        r_i     <= '0;
                        r_b     <= '0;
                        r_rp    <= r_wslot;
                        r_state <= S_BR_RD;
                    end
                end
                S_BR_RD: begin
                    if (r_i < r_n) begin
                        r_state <= S_BR_CHK;
                    end else begin
                        r_prof  <= (((CNT_W+3)'(r_b) * (CNT_W+3)'(5)) > (CNT_W+3)'(r_n)) ?
                                   PRF_BURSTY : PRF_PERIODIC;
                        r_state <= S_FIN;
                    end
                end
                S_BR_CHK: begin
                    r_i       <= r_i + 1'b1;
                    r_rp      <= rp_prev;
                    r_req     <= '{go: 1'b1, op: ALU_MUL};
                    r_alu_a   <= ACC_W'(rd_rate);
                    r_alu_b   <= SUM_W'(r_n);
                    r_alu_acc <= '0;
                    r_state   <= S_BR_MUL;
                end
                S_BR_MUL: begin
                    if (alu_done) begin
                        if ({alu_res[ACC_W-5:0], 4'b0000} > r_sr) r_b <= r_b + 1'b1;
                        r_state <= S_BR_RD;
                    end
                end
                S_FIN: begin
                    if (fin_load) begin
                        r_cur_prof <= r_prof;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result register: loaded once per tick, held until the beat is taken.
    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            o_moving_avg_bps  <= r_avg;
            o_rx_bps          <= r_rx;
            o_tx_bps          <= r_tx;
            o_peak_bps        <= r_peak;
            o_period_packets  <= r_pkts;
            o_burst_flag      <= r_burst;
            o_idle_event      <= r_idle_ev;
            o_profile         <= r_prof;
            o_profile_changed <= (r_prof != r_cur_prof);
            o_burst_total     <= r_burst_cnt;
            o_idle_total      <= r_idle_cnt;
        end
    end

endmodule
`default_nettype wire
